// ===== hw/rtl/mtrr_pkg.sv =====
package mtrr_pkg;

  // fixed sizes of the request path
  localparam int FRAME_BYTES          = 16;
  localparam int MAX_ANALOG_READ      = 13;
  localparam int MAX_BIT_READ         = 256;
  localparam int DEF_NUM_DEVICES      = 8;
  localparam int DEF_POINTS_PER_TABLE = 512;
  localparam int LEN_W                = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W                = $clog2(FRAME_BYTES);
  localparam int GROUP_W              = 9;
  localparam int QUEUE_DEPTH          = 2;

  // input actions
  localparam logic [1:0] ACT_RX_BYTE   = 2'd0;
  localparam logic [1:0] ACT_LOAD_BIN  = 2'd1;
  localparam logic [1:0] ACT_LOAD_ANA  = 2'd2;

  // modbus function codes
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'd6;

  typedef enum logic [2:0] {
    JOB_LOAD_BIN,
    JOB_LOAD_ANA,
    JOB_ECHO,
    JOB_HEADER,
    JOB_BITS,
    JOB_ANALOG
  } job_kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic        rx_last;
    logic [2:0]  load_device;
    logic        load_table;
    logic [8:0]  load_index;
    logic [31:0] load_value;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } result_t;

  typedef struct packed {
    job_kind_t                   kind;
    logic [LEN_W-1:0]            len;
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [7:0]                  count;
    logic [GROUP_W-1:0]          group;
    logic [15:0]                 start;
    logic [15:0]                 qty;
    logic [31:0]                 value;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hw/rtl/mtrr_front.sv =====
module mtrr_front #(
  parameter int NUM_DEVICES      = mtrr_pkg::DEF_NUM_DEVICES,
  parameter int POINTS_PER_TABLE = mtrr_pkg::DEF_POINTS_PER_TABLE
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  mtrr_pkg::item_t         item,
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_data,
  input  mtrr_pkg::queue_status_t q_status,
  input  logic                    clearing,
  output logic                    busy,
  output logic                    push,
  output mtrr_pkg::job_t          push_job
);
  import mtrr_pkg::*;

  logic [7:0]       store [FRAME_BYTES];
  logic [LEN_W-1:0] fill;
  logic             overflow;
  logic [3:0]       devices_in_use;

  logic                        accept;
  logic                        fill_room;
  logic [FRAME_BYTES-1:0][7:0] view;
  logic [LEN_W-1:0]            frame_len;
  logic [15:0]                 mbap;
  logic [15:0]                 qty;
  logic [7:0]                  unit;
  logic [7:0]                  fun;
  logic [7:0]                  ndev;
  logic                        is_echo;
  logic                        is_bits;
  logic                        is_analog;
  logic                        qty_ok;
  logic                        read_ok;
  logic                        table_sel;
  logic [16:0]                 qty_p7;
  logic                        load_ok;

  assign busy      = q_status.full || clearing;
  assign accept    = start && !busy;
  assign fill_room = fill < LEN_W'(FRAME_BYTES);

  // frame as it stands with this beat merged; bytes not reached read as zero
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (LEN_W'(i) < fill) begin
        view[i] = store[i];
      end else if (LEN_W'(i) == fill) begin
        view[i] = item.rx_byte;
      end else begin
        view[i] = 8'd0;
      end
    end
  end

  // classify the finished request
  assign frame_len = fill + LEN_W'(1);
  assign mbap      = {view[4], view[5]};
  assign unit      = view[6];
  assign fun       = view[7];
  assign qty       = {view[10], view[11]};
  assign is_echo   = (frame_len < LEN_W'(6)) || ((16'(frame_len) - 16'd6) != mbap);
  assign ndev      = ({4'd0, devices_in_use} > 8'(NUM_DEVICES)) ? 8'(NUM_DEVICES)
                                                               : {4'd0, devices_in_use};
  assign is_bits   = (fun == FC_READ_COILS) || (fun == FC_READ_DISCRETE);
  assign is_analog = (fun == FC_READ_HOLDING) || (fun == FC_READ_INPUT);
  assign qty_ok    = is_bits ? (qty <= 16'(MAX_BIT_READ)) : (qty <= 16'(MAX_ANALOG_READ));
  assign read_ok   = (is_bits || is_analog) && (unit != 8'd0) && (unit <= ndev) && qty_ok;
  assign table_sel = (fun == FC_READ_COILS) || (fun == FC_READ_HOLDING);
  assign qty_p7    = {1'b0, qty} + 17'd7;
  assign load_ok   = (int'(item.load_device) < NUM_DEVICES) &&
                     (int'(item.load_index) < POINTS_PER_TABLE);

  // job toward the back end
  always_comb begin
    push_job       = '0;
    push_job.kind  = JOB_ECHO;
    push_job.len   = frame_len;
    push_job.bytes = view;
    push_job.start = {view[8], view[9]};
    push_job.qty   = qty;
    push_job.group = {unit - 8'd1, table_sel};
    push           = 1'b0;
    case (item.action)
      ACT_RX_BYTE: begin
        if (is_echo) begin
          push_job.kind = JOB_ECHO;
        end else if (!read_ok) begin
          push_job.kind = JOB_HEADER;
        end else if (is_bits) begin
          push_job.kind  = JOB_BITS;
          push_job.count = 8'(qty_p7 >> 3);
        end else begin
          push_job.kind  = JOB_ANALOG;
          push_job.count = {2'd0, qty[3:0], 2'd0};
        end
        push = accept && item.rx_last && fill_room && !overflow &&
               (is_echo || (fun != FC_WRITE_SINGLE));
      end
      ACT_LOAD_BIN, ACT_LOAD_ANA: begin
        push_job.kind  = (item.action == ACT_LOAD_BIN) ? JOB_LOAD_BIN : JOB_LOAD_ANA;
        push_job.group = {{(GROUP_W-4){1'b0}}, item.load_device, item.load_table};
        push_job.start = {7'd0, item.load_index};
        push_job.value = item.load_value;
        push           = accept && load_ok;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // frame gathering and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      overflow       <= 1'b0;
      devices_in_use <= 4'd0;
    end else begin
      if (cfg_we) begin
        devices_in_use <= cfg_data;
      end
      if (accept && (item.action == ACT_RX_BYTE)) begin
        if (item.rx_last) begin
          fill     <= '0;
          overflow <= 1'b0;
        end else if (fill_room) begin
          fill <= fill + LEN_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
    end
  end

  // frame bytes
  always_ff @(posedge clk) begin
    if (accept && (item.action == ACT_RX_BYTE) && fill_room) begin
      store[fill[IDX_W-1:0]] <= item.rx_byte;
    end
  end

endmodule

// ===== hw/rtl/mtrr_queue.sv =====
module mtrr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mtrr_pkg::job_t          push_job,
  input  logic                    pop,
  output mtrr_pkg::job_t          head,
  output mtrr_pkg::queue_status_t q_status
);
  import mtrr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] used;
  logic          do_push;
  logic          do_pop;

  assign q_status.full  = (used == CW'(QUEUE_DEPTH));
  assign q_status.empty = (used == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entries[rd_ptr];

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + CW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/mtrr_back.sv =====
module mtrr_back #(
  parameter int NUM_DEVICES      = mtrr_pkg::DEF_NUM_DEVICES,
  parameter int POINTS_PER_TABLE = mtrr_pkg::DEF_POINTS_PER_TABLE
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mtrr_pkg::queue_status_t q_status,
  input  mtrr_pkg::job_t          head,
  output logic                    pop,
  output logic                    clearing,
  output logic                    result_valid,
  output mtrr_pkg::result_t       result
);
  import mtrr_pkg::*;

  localparam int DEPTH = NUM_DEVICES * 2 * POINTS_PER_TABLE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HEAD  = 7'b0000100,
    ST_BITS  = 7'b0001000,
    ST_BEMIT = 7'b0010000,
    ST_AREAD = 7'b0100000,
    ST_AEMIT = 7'b1000000
  } state_t;

  logic        bin_mem [DEPTH];
  logic [31:0] ana_mem [DEPTH];

  state_t           state;
  state_t           state_next;
  job_t             cur;
  logic [LEN_W-1:0] k;
  logic [15:0]      i;
  logic [2:0]       bitpos;
  logic [1:0]       sub;
  logic [7:0]       dleft;
  logic [7:0]       acc;
  logic [7:0]       acc_merged;
  logic             pend;
  logic             flag_q;
  logic [2:0]       pos_q;
  logic             ana_flag;
  logic [AW-1:0]    base;
  logic [AW-1:0]    clr_addr;
  logic             bin_rd;
  logic [31:0]      ana_rd;

  logic [AW-1:0] head_base;
  logic [AW-1:0] wr_addr;
  logic          bin_we;
  logic          ana_we;
  logic          bin_wd;
  logic [31:0]   ana_wd;
  logic [16:0]   a;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  logic          bin_re;
  logic          ana_re;
  logic [8:0]    len_word;
  logic [31:0]   word;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          good;

  assign clearing  = (state == ST_CLEAR);
  assign pop       = (state == ST_IDLE) && !q_status.empty;
  assign head_base = AW'(int'(head.group) * POINTS_PER_TABLE);
  assign a         = {1'b0, cur.start} + {1'b0, i};
  assign in_range  = a < 17'(POINTS_PER_TABLE);
  assign rd_addr   = base + AW'(a);
  assign bin_re    = (state == ST_BITS);
  assign ana_re    = (state == ST_AREAD);
  assign len_word  = {1'b0, cur.count} + 9'd3;
  assign word      = ana_flag ? ana_rd : 32'd0;
  assign good      = (cur.kind == JOB_BITS) || (cur.kind == JOB_ANALOG);

  // point memory write port: clearing sweep or host load
  always_comb begin
    wr_addr = clr_addr;
    bin_we  = 1'b0;
    ana_we  = 1'b0;
    bin_wd  = 1'b0;
    ana_wd  = 32'd0;
    if (clearing) begin
      bin_we = 1'b1;
      ana_we = 1'b1;
    end else if (pop) begin
      wr_addr = head_base + AW'(head.start);
      bin_wd  = (head.value != 32'd0);
      ana_wd  = head.value;
      bin_we  = (head.kind == JOB_LOAD_BIN);
      ana_we  = (head.kind == JOB_LOAD_ANA);
    end
  end

  // point memories
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[wr_addr] <= bin_wd;
    end
    if (ana_we) begin
      ana_mem[wr_addr] <= ana_wd;
    end
    if (bin_re) begin
      bin_rd <= bin_mem[rd_addr];
    end
    if (ana_re) begin
      ana_rd <= ana_mem[rd_addr];
    end
  end

  // bit byte with the latest read folded in
  always_comb begin
    acc_merged = acc;
    if (pend) begin
      acc_merged[pos_q] = bin_rd & flag_q;
    end
  end

  // response byte for this cycle and next state
  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_last  = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop && (head.kind != JOB_LOAD_BIN) && (head.kind != JOB_LOAD_ANA)) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        emit = 1'b1;
        if (cur.kind == JOB_ECHO) begin
          emit_byte = cur.bytes[k[IDX_W-1:0]];
          emit_last = (k == cur.len - LEN_W'(1));
        end else begin
          if (k == LEN_W'(4)) begin
            emit_byte = {7'd0, len_word[8]};
          end else if (k == LEN_W'(5)) begin
            emit_byte = len_word[7:0];
          end else if (k == LEN_W'(8)) begin
            emit_byte = cur.count;
          end else begin
            emit_byte = cur.bytes[k[IDX_W-1:0]];
          end
          emit_last = good ? ((k == LEN_W'(8)) && (cur.count == 8'd0))
                           : (k == LEN_W'(7));
        end
        if (emit_last) begin
          state_next = ST_IDLE;
        end else if (good && (k == LEN_W'(8))) begin
          state_next = (cur.kind == JOB_BITS) ? ST_BITS : ST_AREAD;
        end
      end
      ST_BITS: begin
        if (bitpos == 3'd7) begin
          state_next = ST_BEMIT;
        end
      end
      ST_BEMIT: begin
        emit       = 1'b1;
        emit_byte  = acc_merged;
        emit_last  = (dleft == 8'd1);
        state_next = emit_last ? ST_IDLE : ST_BITS;
      end
      ST_AREAD: begin
        state_next = ST_AEMIT;
      end
      ST_AEMIT: begin
        emit = 1'b1;
        case (sub)
          2'd0:    emit_byte = word[15:8];
          2'd1:    emit_byte = word[7:0];
          2'd2:    emit_byte = word[31:24];
          default: emit_byte = word[23:16];
        endcase
        emit_last = (sub == 2'd3) && ((i + 16'd1) == cur.qty);
        if (sub == 2'd3) begin
          state_next = emit_last ? ST_IDLE : ST_AREAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      pend         <= (state == ST_BITS);
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // job registers and counters
  always_ff @(posedge clk) begin
    result.tx_byte <= emit_byte;
    result.tx_last <= emit_last;
    case (state)
      ST_IDLE: begin
        cur    <= head;
        base   <= head_base;
        k      <= '0;
        i      <= 16'd0;
        bitpos <= 3'd0;
        sub    <= 2'd0;
        dleft  <= head.count;
        acc    <= 8'd0;
      end
      ST_HEAD: begin
        k <= k + LEN_W'(1);
      end
      ST_BITS: begin
        acc    <= acc_merged;
        flag_q <= in_range && (i < cur.qty);
        pos_q  <= bitpos;
        i      <= i + 16'd1;
        bitpos <= bitpos + 3'd1;
      end
      ST_BEMIT: begin
        acc   <= 8'd0;
        dleft <= dleft - 8'd1;
      end
      ST_AREAD: begin
        ana_flag <= in_range;
        sub      <= 2'd0;
      end
      ST_AEMIT: begin
        sub <= sub + 2'd1;
        if (sub == 2'd3) begin
          i <= i + 16'd1;
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

// ===== hw/rtl/modbus_tcp_read_responder_unit.sv =====
// Modbus TCP read responder. After reset the unit holds busy high while it
// zeroes the NUM_DEVICES*2*POINTS_PER_TABLE point memory entries (8192 by
// default) one entry a cycle. Request bytes and point loads are then
// taken one a cycle whenever busy is low; busy rises only while the two-entry
// job queue between the front end and the response engine is full. Loads and
// finished requests go through that queue in order, so a load never overtakes
// an earlier request. Responses come out one beat per cycle for header and echo
// bytes; bit reads take one point memory read per bit of each data byte, and
// float reads take one read per point followed by its four bytes. The
// strobe result_valid marks each beat for exactly one cycle and the receiver
// cannot stall it.
module modbus_tcp_read_responder_unit #(
  parameter int NUM_DEVICES      = mtrr_pkg::DEF_NUM_DEVICES,
  parameter int POINTS_PER_TABLE = mtrr_pkg::DEF_POINTS_PER_TABLE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mtrr_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  output logic              result_valid,
  output mtrr_pkg::result_t result
);
  import mtrr_pkg::*;

  queue_status_t q_status;
  job_t          push_job;
  job_t          head;
  logic          push;
  logic          pop;
  logic          clearing;

  // request gathering and classification
  mtrr_front #(
    .NUM_DEVICES      (NUM_DEVICES),
    .POINTS_PER_TABLE (POINTS_PER_TABLE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  mtrr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // response engine and point memories
  mtrr_back #(
    .NUM_DEVICES      (NUM_DEVICES),
    .POINTS_PER_TABLE (POINTS_PER_TABLE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
